>>> design/osg_pkg.sv
`timescale 1ns / 1ps

package osg_pkg;

  localparam int DIST_BITS  = 16;
  localparam int HOLD_TICKS = 150;

  localparam int NUM_SIDES = 4;
  localparam int NUM_REGS  = 8;
  localparam int SENSORS_PER_SIDE = 3;
  localparam int SLOT_BITS = 16;

  localparam logic [SLOT_BITS-1:0] DIST_MASK = SLOT_BITS'((33'd1 << DIST_BITS) - 33'd1);

  // side order inside the block: front, back, left, right
  localparam logic [1:0] SIDE_FRONT = 2'd0;
  localparam logic [1:0] SIDE_BACK  = 2'd1;
  localparam logic [1:0] SIDE_LEFT  = 2'd2;
  localparam logic [1:0] SIDE_RIGHT = 2'd3;

  localparam logic [1:0] LVL_CLEAR = 2'd0;
  localparam logic [1:0] LVL_LIMIT = 2'd1;
  localparam logic [1:0] LVL_STOP  = 2'd2;

  localparam logic [3:0] MASK_FRONT = 4'h1;
  localparam logic [3:0] MASK_RIGHT = 4'h2;
  localparam logic [3:0] MASK_BACK  = 4'h4;
  localparam logic [3:0] MASK_LEFT  = 4'h8;
  localparam logic [3:0] MASK_ALL   = 4'hF;

  // Q8.8 thresholds
  localparam logic signed [15:0] Q_HALF_TENTH = 16'sd12;
  localparam logic signed [15:0] Q_TENTH      = 16'sd25;
  localparam logic signed [15:0] Q_NEG_TENTH  = -16'sd25;
  localparam logic signed [15:0] Q_ONE        = 16'sd256;
  localparam logic signed [15:0] Q_NEG_ONE    = -16'sd256;

  localparam int CFG_INDEX_BITS = 4;

  typedef struct packed {
    logic [47:0]        front_distances;
    logic [47:0]        right_distances;
    logic [47:0]        back_distances;
    logic [47:0]        left_distances;
    logic signed [15:0] speed_x;
    logic signed [15:0] speed_y;
  } osg_in_t;

  typedef struct packed {
    logic signed [15:0] safe_speed_x;
    logic signed [15:0] safe_speed_y;
    logic [1:0]         level_front;
    logic [1:0]         level_back;
    logic [1:0]         level_left;
    logic [1:0]         level_right;
    logic [3:0]         sensor_mask;
  } osg_out_t;

endpackage

>>> design/obstacle_speed_governor_top.sv
`timescale 1ns / 1ps

// Registered path: a request is captured in the input register, then moves into the result
// register once the output is free to take it.
// Throughput: one request per cycle while results are taken; a stalled result still lets the input register fill.
// Per-side level and hold counter advance once per request as it moves into the result register.
// Reset (async, active low) clears levels, hold counters, thresholds and all valid flags.
module obstacle_speed_governor_top
  import osg_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  osg_in_t                   in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output osg_out_t                  out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  logic [15:0]               cfg_data_i
);

  logic [15:0] cfg_q [NUM_REGS];

  logic        s1_valid_q;
  osg_in_t     s1_data_q;
  logic        s1_advance;

  logic        out_valid_q;
  osg_out_t    out_data_q;

  logic [1:0]  lvl_q [NUM_SIDES];
  logic [1:0]  lvl_d [NUM_SIDES];
  logic [7:0]  cnt_q [NUM_SIDES];
  logic [7:0]  cnt_d [NUM_SIDES];

  logic [47:0] pack [NUM_SIDES];
  logic [NUM_SIDES-1:0] near, brake;

  logic signed [15:0] gov_x, gov_y;
  logic [3:0]  mask;
  logic [16:0] ax, ay;
  logic [17:0] abs_sum;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_q[i] <= '0;
    end else if (cfg_valid_i && cfg_index_i < CFG_INDEX_BITS'(NUM_REGS)) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  assign s1_advance  = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  assign pack[SIDE_FRONT] = s1_data_q.front_distances;
  assign pack[SIDE_BACK]  = s1_data_q.back_distances;
  assign pack[SIDE_LEFT]  = s1_data_q.left_distances;
  assign pack[SIDE_RIGHT] = s1_data_q.right_distances;

  always_comb begin
    logic [15:0] d;
    d = '0;
    for (int s = 0; s < NUM_SIDES; s++) begin
      near[s]  = 1'b0;
      brake[s] = 1'b0;
      for (int k = 0; k < SENSORS_PER_SIDE; k++) begin
        d = pack[s][SLOT_BITS*k +: SLOT_BITS] & DIST_MASK;
        if (d < cfg_q[3'(s)]) near[s] = 1'b1;
        if (d < cfg_q[3'(NUM_SIDES + s)]) brake[s] = 1'b1;
      end
    end
  end

  // A counted tick either increments the hold counter or, once it has reached
  // HOLD_TICKS, drops the level by one and restarts it. Bad readings never clear it.
  always_comb begin
    logic       count;
    logic [1:0] lower;
    count = 1'b0;
    lower = LVL_CLEAR;
    for (int s = 0; s < NUM_SIDES; s++) begin
      lvl_d[s] = lvl_q[s];
      cnt_d[s] = cnt_q[s];
      count    = 1'b0;
      lower    = LVL_CLEAR;
      case (lvl_q[s])
        LVL_CLEAR: begin
          if (near[s]) lvl_d[s] = LVL_LIMIT;
        end
        LVL_LIMIT: begin
          if (brake[s]) begin
            lvl_d[s] = LVL_STOP;
          end else if (!near[s]) begin
            count = 1'b1;
            lower = LVL_CLEAR;
          end
        end
        LVL_STOP: begin
          if (!brake[s]) begin
            count = 1'b1;
            lower = LVL_LIMIT;
          end
        end
        default: ;
      endcase
      if (count) begin
        if (cnt_q[s] >= 8'(HOLD_TICKS)) begin
          lvl_d[s] = lower;
          cnt_d[s] = '0;
        end else begin
          cnt_d[s] = cnt_q[s] + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SIDES; s++) begin
        lvl_q[s] <= LVL_CLEAR;
        cnt_q[s] <= '0;
      end
    end else if (s1_advance) begin
      for (int s = 0; s < NUM_SIDES; s++) begin
        lvl_q[s] <= lvl_d[s];
        cnt_q[s] <= cnt_d[s];
      end
    end
  end

  function automatic logic signed [15:0] govern(input logic signed [15:0] v,
                                                input logic [1:0] pos_lvl,
                                                input logic [1:0] neg_lvl);
    logic signed [15:0] r;
    r = v;
    if (v > Q_HALF_TENTH) begin
      if (pos_lvl == LVL_STOP) r = '0;
      else if (pos_lvl == LVL_LIMIT && v > Q_ONE) r = Q_ONE;
    end else begin
      if (neg_lvl == LVL_STOP) r = '0;
      else if (neg_lvl == LVL_LIMIT && v < Q_NEG_ONE) r = Q_NEG_ONE;
    end
    return r;
  endfunction

  assign gov_x = govern(s1_data_q.speed_x, lvl_d[SIDE_FRONT], lvl_d[SIDE_BACK]);
  assign gov_y = govern(s1_data_q.speed_y, lvl_d[SIDE_LEFT], lvl_d[SIDE_RIGHT]);

  assign ax = s1_data_q.speed_x[15] ? 17'(-{s1_data_q.speed_x[15], s1_data_q.speed_x})
                                    : {1'b0, s1_data_q.speed_x};
  assign ay = s1_data_q.speed_y[15] ? 17'(-{s1_data_q.speed_y[15], s1_data_q.speed_y})
                                    : {1'b0, s1_data_q.speed_y};
  assign abs_sum = {1'b0, ax} + {1'b0, ay};

  always_comb begin
    mask = '0;
    if (s1_data_q.speed_x > Q_TENTH) mask = mask | MASK_FRONT;
    else if (s1_data_q.speed_x < Q_NEG_TENTH) mask = mask | MASK_BACK;
    if (s1_data_q.speed_y > Q_TENTH) mask = mask | MASK_LEFT;
    else if (s1_data_q.speed_y < Q_NEG_TENTH) mask = mask | MASK_RIGHT;
    if (abs_sum <= 18'(Q_TENTH)) mask = MASK_ALL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_data_q.safe_speed_x <= gov_x;
      out_data_q.safe_speed_y <= gov_y;
      out_data_q.level_front  <= lvl_d[SIDE_FRONT];
      out_data_q.level_back   <= lvl_d[SIDE_BACK];
      out_data_q.level_left   <= lvl_d[SIDE_LEFT];
      out_data_q.level_right  <= lvl_d[SIDE_RIGHT];
      out_data_q.sensor_mask  <= mask;
    end
  end

endmodule

>>> design/osg_checker.sv
`timescale 1ns / 1ps

module osg_checker
  import osg_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input osg_out_t                  out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // forward travel into a stopped front side must not come out above Q_HALF_TENTH
  a_front_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.level_front == LVL_STOP |->
      out_data_o.safe_speed_x <= Q_HALF_TENTH)
    else $error("speed passed through front stop");

  a_front_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.level_front == LVL_LIMIT |->
      out_data_o.safe_speed_x <= Q_ONE)
    else $error("speed above limit with front in limit level");

endmodule

bind obstacle_speed_governor_top osg_checker u_osg_checker (.*);
